// File: hdl/rpsch_pkg.sv
// shared constants and types for the priority thread scheduler
`default_nettype none
package rpsch_pkg;
   localparam int NUM_THREADS = 8;
   localparam int NUM_PRIOS   = 16;
   localparam int NUM_SEMS    = 4;
   localparam int NUM_LISTS   = NUM_SEMS + 2;
   localparam int TID_W       = $clog2(NUM_THREADS);
   localparam int LNK_W       = TID_W + 1;
   localparam int PRIO_W      = 4;
   localparam int LIST_W      = $clog2(NUM_LISTS);
   localparam int TAG_W       = $clog2(NUM_LISTS + 1);
   localparam int SEM_W       = 2;
   localparam logic [LNK_W-1:0] NIL = LNK_W'(NUM_THREADS);
   localparam logic [PRIO_W-1:0] PRIO_LOW = PRIO_W'(NUM_PRIOS - 1);

   // thread states
   localparam logic [1:0] ST_UNUSED  = 2'd0;
   localparam logic [1:0] ST_READY   = 2'd1;
   localparam logic [1:0] ST_SLEEP   = 2'd2;
   localparam logic [1:0] ST_BLOCKED = 2'd3;

   localparam logic [LIST_W-1:0] L_READY = LIST_W'(0);
   localparam logic [LIST_W-1:0] L_SLEEP = LIST_W'(1);

   // actions
   localparam logic [3:0] ACT_TICK = 4'd0;
   localparam logic [3:0] ACT_YIELD = 4'd1;
   localparam logic [3:0] ACT_CREATE = 4'd2;
   localparam logic [3:0] ACT_SLEEP = 4'd3;
   localparam logic [3:0] ACT_TERM = 4'd4;
   localparam logic [3:0] ACT_EXIT = 4'd5;
   localparam logic [3:0] ACT_SINIT = 4'd6;
   localparam logic [3:0] ACT_SWAIT = 4'd7;
   localparam logic [3:0] ACT_STRY = 4'd8;
   localparam logic [3:0] ACT_SSIG = 4'd9;

   // status codes
   localparam logic [2:0] STS_OK = 3'd0;
   localparam logic [2:0] STS_BAD = 3'd1;
   localparam logic [2:0] STS_NOFREE = 3'd2;
   localparam logic [2:0] STS_BLOCK = 3'd3;
   localparam logic [2:0] STS_OVF = 3'd4;
   localparam logic [2:0] STS_CBLK = 3'd5;

   // key compare request to the shared comparator
   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
   } cmp_req_type;

   typedef struct packed {
      logic gt;
      logic lt;
   } cmp_rsp_type;
endpackage
`default_nettype wire

// File: hdl/rpsch_cmp.sv
// shared unsigned key comparator for sorted insertion walks, the tick due check and the preempt check
`default_nettype none
module rpsch_cmp (
   input  wire rpsch_pkg::cmp_req_type req,
   output rpsch_pkg::cmp_rsp_type      rsp
);
   import rpsch_pkg::*;
   // one 32 bit magnitude compare
   always_comb begin
      rsp.gt = req.a > req.b;
      rsp.lt = req.a < req.b;
   end
endmodule
`default_nettype wire

// File: hdl/rtos_priority_scheduler_with_semaphores_core.sv
// top level: command sequencer with list walks over one shared comparator
// commands with no list work pass through dispatch to the result; a sorted insertion
//   walks the target list entry by entry, a reschedule reinserts a still ready running
//   thread and then pops the ready head; a tick checks the sleep list head, inserting
//   each due sleeper into the ready list, then makes the preempt check
// one command at a time; req_stall is high from transfer to result taken
// reset: synchronous, active high; thread 0 alone in the ready list, no thread runs
`default_nettype none
module rtos_priority_scheduler_with_semaphores_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [3:0]  req_action,
   input  wire  [2:0]  req_thread_id,
   input  wire  [3:0]  req_prio,
   input  wire  [31:0] req_ticks,
   input  wire  [1:0]  req_sem_id,
   input  wire  [15:0] req_sem_value,
   input  wire  [15:0] req_sem_max,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [2:0]  rsp_result_id,
   output logic        rsp_active_valid,
   output logic [2:0]  rsp_active_id,
   output logic        rsp_switched
);
   import rpsch_pkg::*;

   // sequencer states
   localparam logic [3:0] S_IDLE = 4'd0, S_DISP = 4'd1, S_INS = 4'd2,
      S_WALK = 4'd3, S_RSCH = 4'd4, S_POP = 4'd5, S_TWAKE = 4'd6,
      S_TCHK = 4'd7, S_REM = 4'd8, S_SCLR = 4'd9, S_DONE = 4'd10;
   // what follows a sorted insertion
   localparam logic [1:0] N_DONE = 2'd0, N_RSCH = 2'd1, N_POP = 2'd2,
      N_TWAKE = 2'd3;

   logic [3:0]  state_ff, state_in;
   logic [1:0]  nxt_ff, nxt_in;
   logic [3:0]  act_ff, act_in;
   logic [2:0]  tid_ff, tid_in;
   logic [3:0]  prio_ff, prio_in;
   logic [31:0] ticks_ff, ticks_in;
   logic [1:0]  sid_ff, sid_in;
   logic [15:0] sval_ff, sval_in;
   logic [15:0] smax_ff, smax_in;

   logic [31:0] tick_ff, tick_in;
   logic        rv_ff, rv_in;
   logic [TID_W-1:0] rid_ff, rid_in;
   logic [1:0]  tst_ff [NUM_THREADS], tst_in [NUM_THREADS];
   logic [PRIO_W-1:0] tpr_ff [NUM_THREADS], tpr_in [NUM_THREADS];
   logic [31:0] key_ff [NUM_THREADS], key_in [NUM_THREADS];
   logic [LNK_W-1:0] lnk_ff [NUM_THREADS], lnk_in [NUM_THREADS];
   logic [TAG_W-1:0] tag_ff [NUM_THREADS], tag_in [NUM_THREADS];
   logic [LNK_W-1:0] hd_ff [NUM_LISTS], hd_in [NUM_LISTS];
   logic [LNK_W-1:0] tl_ff [NUM_LISTS], tl_in [NUM_LISTS];
   logic [15:0] scnt_ff [NUM_SEMS], scnt_in [NUM_SEMS];
   logic [15:0] slim_ff [NUM_SEMS], slim_in [NUM_SEMS];

   // walk registers: thread being inserted, list, cursor
   logic [TID_W-1:0]  t_ff, t_in;
   logic [LIST_W-1:0] l_ff, l_in;
   logic [TID_W-1:0]  it_ff, it_in;
   logic [3:0]        guard_ff, guard_in;
   logic [2:0]  sts_ff, sts_in;
   logic [2:0]  res_ff, res_in;
   logic        sw_ff, sw_in;

   cmp_req_type creq;
   cmp_rsp_type crsp;
   rpsch_cmp u_cmp (.req(creq), .rsp(crsp));

   logic [LNK_W-1:0] succ;
   logic [TID_W-1:0] free_id;
   logic             free_ok;
   logic [LIST_W-1:0] sl;

   assign succ = lnk_ff[it_ff];
   assign sl = LIST_W'(sid_ff) + LIST_W'(2);

   // lowest unused thread id
   always_comb begin
      free_id = '0;
      free_ok = 1'b0;
      for (int i = NUM_THREADS - 1; i >= 0; i--) begin
         if (tst_ff[i] == ST_UNUSED) begin
            free_id = TID_W'(i);
            free_ok = 1'b1;
         end
      end
   end

   // comparator operands by state
   always_comb begin
      creq.a = key_ff[t_ff];
      creq.b = key_ff[it_ff];
      if (state_ff == S_WALK) begin
         creq.b = key_ff[succ[TID_W-1:0]];
      end else if (state_ff == S_INS) begin
         creq.b = key_ff[hd_ff[l_ff][TID_W-1:0]];
      end else if (state_ff == S_TCHK) begin
         creq.a = tick_ff;
         creq.b = key_ff[hd_ff[L_SLEEP][TID_W-1:0]];
      end else if (state_ff == S_DISP) begin
         creq.a = {28'd0, tpr_ff[hd_ff[L_READY][TID_W-1:0]]};
         creq.b = {28'd0, tpr_ff[rid_ff]};
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);
   assign rsp_status = sts_ff;
   assign rsp_result_id = res_ff;
   assign rsp_active_valid = rv_ff;
   assign rsp_active_id = rv_ff ? 3'(rid_ff) : 3'd0;
   assign rsp_switched = sw_ff;

   // sequencer
   always_comb begin
      logic [TID_W-1:0] h;
      logic [LIST_W-1:0] lr;
      state_in = state_ff; nxt_in = nxt_ff;
      act_in = act_ff; tid_in = tid_ff; prio_in = prio_ff; ticks_in = ticks_ff;
      sid_in = sid_ff; sval_in = sval_ff; smax_in = smax_ff;
      tick_in = tick_ff; rv_in = rv_ff; rid_in = rid_ff;
      tst_in = tst_ff; tpr_in = tpr_ff; key_in = key_ff; lnk_in = lnk_ff;
      tag_in = tag_ff; hd_in = hd_ff; tl_in = tl_ff;
      scnt_in = scnt_ff; slim_in = slim_ff;
      t_in = t_ff; l_in = l_ff; it_in = it_ff; guard_in = guard_ff;
      sts_in = sts_ff; res_in = res_ff; sw_in = sw_ff;
      h = '0; lr = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in = req_action; tid_in = req_thread_id; prio_in = req_prio;
               ticks_in = req_ticks; sid_in = req_sem_id;
               sval_in = req_sem_value; smax_in = req_sem_max;
               sts_in = STS_OK; res_in = '0; sw_in = 1'b0;
               state_in = S_DISP;
               if (req_action == ACT_TICK) begin
                  tick_in = tick_ff + 32'd1;
                  state_in = S_TCHK;
               end
            end
         end
         S_DISP: begin
            state_in = S_DONE;
            unique case (act_ff)
               ACT_YIELD: state_in = S_RSCH;
               ACT_TICK: begin
                  // preempt check after all wakeups
                  if (hd_ff[L_READY] != NIL && (!rv_ff || crsp.lt)) state_in = S_RSCH;
               end
               ACT_CREATE: begin
                  if (32'(prio_ff) >= 32'(NUM_PRIOS)) sts_in = STS_BAD;
                  else if (!free_ok) sts_in = STS_NOFREE;
                  else begin
                     tpr_in[free_id] = prio_ff; tst_in[free_id] = ST_READY;
                     key_in[free_id] = {28'd0, prio_ff};
                     res_in = 3'(free_id);
                     t_in = free_id; l_in = L_READY; state_in = S_INS;
                     nxt_in = (rv_ff && prio_ff < tpr_ff[rid_ff]) ? N_RSCH : N_DONE;
                  end
               end
               ACT_SLEEP: begin
                  if (!rv_ff) sts_in = STS_BAD;
                  else if (ticks_ff != 32'd0) begin
                     key_in[rid_ff] = ticks_ff + tick_ff;
                     tst_in[rid_ff] = ST_SLEEP;
                     t_in = rid_ff; l_in = L_SLEEP; state_in = S_INS; nxt_in = N_RSCH;
                  end else state_in = S_RSCH;
               end
               ACT_TERM: begin
                  if (tid_ff == 3'd0 || 32'(tid_ff) >= 32'(NUM_THREADS)) sts_in = STS_BAD;
                  else if (rv_ff && TID_W'(tid_ff) == rid_ff) begin
                     tst_in[rid_ff] = ST_UNUSED; state_in = S_RSCH;
                  end else if (tst_ff[TID_W'(tid_ff)] != ST_UNUSED) begin
                     tst_in[TID_W'(tid_ff)] = ST_UNUSED;
                     t_in = TID_W'(tid_ff);
                     h = TID_W'(tid_ff);
                     if (tag_ff[h] == '0 || 32'(tag_ff[h]) > 32'(NUM_LISTS)) begin
                        tag_in[h] = '0;
                     end else begin
                        lr = LIST_W'(tag_ff[h] - TAG_W'(1));
                        l_in = lr;
                        if (hd_ff[lr] == LNK_W'(h)) begin
                           hd_in[lr] = lnk_ff[h];
                           if (lnk_ff[h] == NIL) tl_in[lr] = NIL;
                           lnk_in[h] = NIL; tag_in[h] = '0;
                        end else if (hd_ff[lr] == NIL) begin
                           lnk_in[h] = NIL; tag_in[h] = '0;
                        end else begin
                           it_in = hd_ff[lr][TID_W-1:0]; guard_in = '0;
                           state_in = S_REM;
                        end
                     end
                  end
               end
               ACT_EXIT: begin
                  if (!rv_ff) sts_in = STS_BAD;
                  else begin tst_in[rid_ff] = ST_UNUSED; state_in = S_RSCH; end
               end
               ACT_SINIT: begin
                  if (32'(sid_ff) >= 32'(NUM_SEMS) || sval_ff > smax_ff) sts_in = STS_BAD;
                  else begin
                     slim_in[sid_ff] = smax_ff; scnt_in[sid_ff] = sval_ff;
                     state_in = S_SCLR;
                  end
               end
               ACT_SWAIT: begin
                  if (32'(sid_ff) >= 32'(NUM_SEMS) || !rv_ff) sts_in = STS_BAD;
                  else if (scnt_ff[sid_ff] != 16'd0) scnt_in[sid_ff] = scnt_ff[sid_ff] - 16'd1;
                  else begin
                     // push caller at fifo tail
                     tst_in[rid_ff] = ST_BLOCKED;
                     lnk_in[rid_ff] = NIL; tag_in[rid_ff] = TAG_W'(sl) + TAG_W'(1);
                     if (hd_ff[sl] == NIL) hd_in[sl] = LNK_W'(rid_ff);
                     else lnk_in[tl_ff[sl][TID_W-1:0]] = LNK_W'(rid_ff);
                     tl_in[sl] = LNK_W'(rid_ff);
                     sts_in = STS_CBLK; state_in = S_RSCH;
                  end
               end
               ACT_STRY: begin
                  if (32'(sid_ff) >= 32'(NUM_SEMS)) sts_in = STS_BAD;
                  else if (scnt_ff[sid_ff] != 16'd0) scnt_in[sid_ff] = scnt_ff[sid_ff] - 16'd1;
                  else sts_in = STS_BLOCK;
               end
               ACT_SSIG: begin
                  if (32'(sid_ff) >= 32'(NUM_SEMS)) sts_in = STS_BAD;
                  else if (hd_ff[sl] != NIL) begin
                     h = hd_ff[sl][TID_W-1:0];
                     hd_in[sl] = lnk_ff[h];
                     if (lnk_ff[h] == NIL) tl_in[sl] = NIL;
                     tst_in[h] = ST_READY; key_in[h] = {28'd0, tpr_ff[h]};
                     t_in = h; l_in = L_READY; state_in = S_INS; nxt_in = N_DONE;
                  end else if (scnt_ff[sid_ff] == slim_ff[sid_ff]) sts_in = STS_OVF;
                  else scnt_in[sid_ff] = scnt_ff[sid_ff] + 16'd1;
               end
               default: sts_in = STS_BAD;
            endcase
         end
         // sorted insertion, head step
         S_INS: begin
            tag_in[t_ff] = TAG_W'(l_ff) + TAG_W'(1);
            if (hd_ff[l_ff] == NIL) begin
               lnk_in[t_ff] = NIL; hd_in[l_ff] = LNK_W'(t_ff); tl_in[l_ff] = LNK_W'(t_ff);
               state_in = S_POP;
            end else begin
               it_in = hd_ff[l_ff][TID_W-1:0]; guard_in = '0;
               state_in = S_WALK;
            end
            // new entry goes ahead of a nonempty list's head only when the head key is strictly greater
            if (hd_ff[l_ff] != NIL && crsp.lt) begin
               lnk_in[t_ff] = hd_ff[l_ff]; hd_in[l_ff] = LNK_W'(t_ff);
               state_in = S_POP;
            end
         end
         // one list entry per cycle through the comparator
         S_WALK: begin
            if (succ != NIL && 32'(guard_ff) < 32'(NUM_THREADS) && crsp.gt) begin
               it_in = succ[TID_W-1:0]; guard_in = guard_ff + 4'd1;
            end else if (succ == NIL) begin
               lnk_in[t_ff] = NIL; lnk_in[tl_ff[l_ff][TID_W-1:0]] = LNK_W'(t_ff);
               tl_in[l_ff] = LNK_W'(t_ff);
               state_in = S_POP;
            end else begin
               lnk_in[it_ff] = LNK_W'(t_ff); lnk_in[t_ff] = succ;
               state_in = S_POP;
            end
         end
         // continuation after insertion
         S_POP: begin
            unique case (nxt_ff)
               N_DONE: state_in = S_DONE;
               N_RSCH: state_in = S_RSCH;
               N_POP: begin
                  // reschedule tail: pop ready head
                  sw_in = 1'b1; state_in = S_DONE;
                  if (hd_ff[L_READY] == NIL) begin
                     rv_in = 1'b0; rid_in = '0;
                  end else begin
                     h = hd_ff[L_READY][TID_W-1:0];
                     hd_in[L_READY] = lnk_ff[h];
                     if (lnk_ff[h] == NIL) tl_in[L_READY] = NIL;
                     lnk_in[h] = NIL; tag_in[h] = '0;
                     rv_in = 1'b1; rid_in = h;
                  end
               end
               N_TWAKE: state_in = S_TCHK;
            endcase
         end
         S_RSCH: begin
            nxt_in = N_POP; state_in = S_POP;
            if (rv_ff && tst_ff[rid_ff] == ST_READY) begin
               key_in[rid_ff] = {28'd0, tpr_ff[rid_ff]};
               t_in = rid_ff; l_in = L_READY; state_in = S_INS;
            end
         end
         // tick: is the sleep head due
         S_TCHK: begin
            if (hd_ff[L_SLEEP] != NIL && !crsp.lt) begin
               h = hd_ff[L_SLEEP][TID_W-1:0];
               hd_in[L_SLEEP] = lnk_ff[h];
               if (lnk_ff[h] == NIL) tl_in[L_SLEEP] = NIL;
               tst_in[h] = ST_READY; key_in[h] = {28'd0, tpr_ff[h]};
               t_in = h; l_in = L_READY; nxt_in = N_TWAKE; state_in = S_INS;
            end else state_in = S_DISP;
         end
         S_TWAKE: state_in = S_TCHK;
         // unlink from the middle of a list
         S_REM: begin
            if (succ == LNK_W'(t_ff)) begin
               lnk_in[it_ff] = lnk_ff[t_ff];
               if (tl_ff[l_ff] == LNK_W'(t_ff)) tl_in[l_ff] = LNK_W'(it_ff);
               lnk_in[t_ff] = NIL; tag_in[t_ff] = '0; state_in = S_DONE;
            end else if (succ == NIL || 32'(guard_ff) >= 32'(NUM_THREADS)) begin
               lnk_in[t_ff] = NIL; tag_in[t_ff] = '0; state_in = S_DONE;
            end else begin
               it_in = succ[TID_W-1:0]; guard_in = guard_ff + 4'd1;
            end
         end
         // drop semaphore wait list one entry per cycle
         S_SCLR: begin
            if (hd_ff[sl] == NIL) state_in = S_DONE;
            else begin
               h = hd_ff[sl][TID_W-1:0];
               hd_in[sl] = lnk_ff[h];
               if (lnk_ff[h] == NIL) tl_in[sl] = NIL;
               lnk_in[h] = NIL; tag_in[h] = '0;
            end
         end
         S_DONE: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      act_ff <= act_in; tid_ff <= tid_in; prio_ff <= prio_in; ticks_ff <= ticks_in;
      sid_ff <= sid_in; sval_ff <= sval_in; smax_ff <= smax_in;
      t_ff <= t_in; l_ff <= l_in; it_ff <= it_in; guard_ff <= guard_in;
      sts_ff <= sts_in; res_ff <= res_in; sw_ff <= sw_in; nxt_ff <= nxt_in;
      if (reset) begin
         state_ff <= S_IDLE; tick_ff <= '0; rv_ff <= 1'b0; rid_ff <= '0;
         for (int i = 0; i < NUM_THREADS; i++) begin
            tst_ff[i] <= (i == 0) ? ST_READY : ST_UNUSED;
            tpr_ff[i] <= (i == 0) ? PRIO_LOW : '0;
            key_ff[i] <= (i == 0) ? {28'd0, PRIO_LOW} : '0;
            lnk_ff[i] <= NIL;
            tag_ff[i] <= (i == 0) ? TAG_W'(1) : '0;
         end
         for (int i = 0; i < NUM_LISTS; i++) begin
            hd_ff[i] <= (i == 0) ? LNK_W'(0) : NIL;
            tl_ff[i] <= (i == 0) ? LNK_W'(0) : NIL;
         end
         for (int i = 0; i < NUM_SEMS; i++) begin
            scnt_ff[i] <= '0; slim_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in; tick_ff <= tick_in; rv_ff <= rv_in; rid_ff <= rid_in;
         tst_ff <= tst_in; tpr_ff <= tpr_in; key_ff <= key_in; lnk_ff <= lnk_in;
         tag_ff <= tag_in; hd_ff <= hd_in; tl_ff <= tl_in;
         scnt_ff <= scnt_in; slim_ff <= slim_in;
      end
   end
endmodule
`default_nettype wire
